[rtl/core/lkhc_pkg.sv]
// Shared types, constants and helpers for the keyed handle cache.
package lkhc_pkg;

   localparam int CAPACITY = 64;
   localparam int SLOT_W   = $clog2(CAPACITY);
   localparam int COUNT_W  = $clog2(CAPACITY + 1);
   localparam int KEY_W    = 64;
   localparam int HANDLE_W = 32;
   localparam int CMD_W    = 2;
   localparam int LIMIT_W  = 7;
   localparam int EVICT_W  = 7;

   localparam logic [LIMIT_W-1:0] LIMIT_RESET = LIMIT_W'(64);

   typedef enum logic [CMD_W-1:0] {
      CMD_LOOKUP = 2'd0,
      CMD_INSERT = 2'd1,
      CMD_CLEAR  = 2'd2,
      CMD_NONE   = 2'd3
   } cmd_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_COMPARE,
      ST_RESOLVE,
      ST_TOUCH,
      ST_EVICT,
      ST_INSERT,
      ST_CLEAR,
      ST_RESULT
   } state_type;

   typedef struct packed {
      logic load;
      logic resolve;
      logic touch;
      logic evict;
      logic insert;
      logic clear;
      logic rsp_load;
   } dp_cmd_type;

   typedef struct packed {
      cmd_type cmd;
      logic    present;
      logic    any_match;
      logic    need_evict;
   } dp_status_type;

   function automatic logic [SLOT_W-1:0] first_set(input logic [CAPACITY-1:0] vec);
      logic [SLOT_W-1:0] idx;
      idx = '0;
      for (int i = CAPACITY - 1; i >= 0; i--) begin
         if (vec[i]) begin
            idx = SLOT_W'(i);
         end
      end
      return idx;
   endfunction

endpackage

[rtl/core/lkhc_ram.sv]
// Generic single-write, single-read RAM with registered read data.
module lkhc_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 64
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

[rtl/core/lkhc_ctrl.sv]
// Sequencing state machine for the keyed handle cache.
module lkhc_ctrl import lkhc_pkg::*; (
   input  logic          clock,
   input  logic          reset,
   input  logic          req_valid,
   output logic          req_ready,
   output logic          rsp_valid,
   input  logic          rsp_ready,
   input  dp_status_type status,
   output dp_cmd_type    cmd
);

   state_type state_ff, state_in;
   logic      rsp_valid_ff, rsp_valid_in;
   logic      rsp_free;

   assign rsp_free = !rsp_valid_ff || rsp_ready;

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               state_in = ST_COMPARE;
            end
         end
         ST_COMPARE: state_in = ST_RESOLVE;
         ST_RESOLVE: begin
            unique case (status.cmd)
               CMD_LOOKUP: state_in = status.any_match ? ST_TOUCH : ST_RESULT;
               CMD_INSERT: begin
                  if (!status.present) begin
                     state_in = ST_RESULT;
                  end else begin
                     state_in = status.any_match ? ST_TOUCH : ST_EVICT;
                  end
               end
               CMD_CLEAR: state_in = ST_CLEAR;
               CMD_NONE:  state_in = ST_RESULT;
               default:   state_in = ST_RESULT;
            endcase
         end
         ST_TOUCH: state_in = ST_RESULT;
         ST_EVICT: begin
            if (!status.need_evict) begin
               state_in = ST_INSERT;
            end
         end
         ST_INSERT: state_in = ST_RESULT;
         ST_CLEAR:  state_in = ST_RESULT;
         ST_RESULT: begin
            if (rsp_free) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      cmd          = '0;
      req_ready    = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            req_ready = 1'b1;
            cmd.load  = req_valid;
         end
         ST_RESOLVE: cmd.resolve = 1'b1;
         ST_TOUCH:  cmd.touch    = 1'b1;
         ST_EVICT:  cmd.evict    = status.need_evict;
         ST_INSERT: cmd.insert   = 1'b1;
         ST_CLEAR:  cmd.clear    = 1'b1;
         ST_RESULT: cmd.rsp_load = rsp_free;
         default: begin
            cmd = '0;
         end
      endcase
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (cmd.rsp_load) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;

   a_ready_idle: assert property (@(posedge clock) disable iff (reset)
      req_ready |-> state_ff == ST_IDLE)
      else $error("ready outside idle");

   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      cmd.rsp_load |-> !(rsp_valid_ff && !rsp_ready))
      else $error("result overwritten");

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && !rsp_ready |=> rsp_valid_ff)
      else $error("result dropped while stalled");

endmodule

[rtl/core/lkhc_dp.sv]
// Tag lanes, recency ranks, handle storage and result register.
module lkhc_dp import lkhc_pkg::*; (
   input  logic                clock,
   input  logic                reset,
   input  dp_cmd_type          cmd,
   output dp_status_type       status,
   input  logic [CMD_W-1:0]    req_cmd,
   input  logic [KEY_W-1:0]    req_key,
   input  logic [HANDLE_W-1:0] req_handle_in,
   input  logic                req_handle_present,
   input  logic                csr_valid,
   input  logic [LIMIT_W-1:0]  csr_capacity_limit,
   output logic                rsp_hit,
   output logic [HANDLE_W-1:0] rsp_handle_out,
   output logic [EVICT_W-1:0]  rsp_evicted_count
);

   cmd_type             cmd_ff;
   logic [KEY_W-1:0]    key_ff;
   logic [HANDLE_W-1:0] handle_ff;
   logic                present_ff;
   logic [LIMIT_W-1:0]  limit_ff;

   logic [KEY_W-1:0]    keys_ff  [CAPACITY];
   logic [SLOT_W-1:0]   rank_ff  [CAPACITY];
   logic [CAPACITY-1:0] valid_ff;
   logic [COUNT_W-1:0]  count_ff;

   logic [CAPACITY-1:0] match_in, match_ff;
   logic                hit_ff;
   logic [SLOT_W-1:0]   slot_ff;
   logic [SLOT_W-1:0]   hit_rank_in, hit_rank_ff;
   logic [EVICT_W-1:0]  evicted_ff;

   logic                rsp_hit_ff;
   logic [HANDLE_W-1:0] rsp_handle_ff;
   logic [EVICT_W-1:0]  rsp_evicted_ff;

   logic [COUNT_W-1:0]  limit_eff;
   logic [COUNT_W-1:0]  oldest_rank;
   logic [SLOT_W-1:0]   free_slot;
   logic                ram_wr_en;
   logic [SLOT_W-1:0]   ram_wr_addr;
   logic [HANDLE_W-1:0] ram_rd_data;
   logic                result_hit;

   always_comb begin
      if (COUNT_W'(limit_ff) > COUNT_W'(CAPACITY)) begin
         limit_eff = COUNT_W'(CAPACITY);
      end else if (limit_ff == '0) begin
         limit_eff = COUNT_W'(1);
      end else begin
         limit_eff = COUNT_W'(limit_ff);
      end
   end

   assign oldest_rank = count_ff - COUNT_W'(1);
   assign free_slot   = first_set(~valid_ff);

   always_comb begin
      hit_rank_in = '0;
      for (int i = 0; i < CAPACITY; i++) begin
         match_in[i] = valid_ff[i] && (keys_ff[i] == key_ff);
         hit_rank_in = hit_rank_in | (match_ff[i] ? rank_ff[i] : '0);
      end
   end

   assign status.cmd        = cmd_ff;
   assign status.present    = present_ff;
   assign status.any_match  = |match_ff;
   assign status.need_evict = (count_ff >= limit_eff) && (count_ff != '0);

   always_ff @(posedge clock) begin
      if (reset) begin
         limit_ff <= LIMIT_RESET;
      end else if (csr_valid) begin
         limit_ff <= csr_capacity_limit;
      end
   end

   always_ff @(posedge clock) begin
      match_ff <= match_in;
      if (cmd.load) begin
         cmd_ff     <= cmd_type'(req_cmd);
         key_ff     <= req_key;
         handle_ff  <= req_handle_in;
         present_ff <= req_handle_present;
         evicted_ff <= '0;
      end else if (cmd.evict) begin
         evicted_ff <= evicted_ff + EVICT_W'(1);
      end
      if (cmd.resolve) begin
         hit_ff      <= |match_ff;
         slot_ff     <= first_set(match_ff);
         hit_rank_ff <= hit_rank_in;
      end
      if (cmd.insert) begin
         keys_ff[free_slot] <= key_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
         count_ff <= '0;
         for (int i = 0; i < CAPACITY; i++) begin
            rank_ff[i] <= '0;
         end
      end else if (cmd.clear) begin
         valid_ff <= '0;
         count_ff <= '0;
         for (int i = 0; i < CAPACITY; i++) begin
            rank_ff[i] <= '0;
         end
      end else if (cmd.touch) begin
         for (int i = 0; i < CAPACITY; i++) begin
            if (SLOT_W'(i) == slot_ff) begin
               rank_ff[i] <= '0;
            end else if (valid_ff[i] && rank_ff[i] < hit_rank_ff) begin
               rank_ff[i] <= rank_ff[i] + SLOT_W'(1);
            end
         end
      end else if (cmd.evict) begin
         count_ff <= count_ff - COUNT_W'(1);
         for (int i = 0; i < CAPACITY; i++) begin
            if (valid_ff[i] && COUNT_W'(rank_ff[i]) == oldest_rank) begin
               valid_ff[i] <= 1'b0;
               rank_ff[i]  <= '0;
            end
         end
      end else if (cmd.insert) begin
         count_ff <= count_ff + COUNT_W'(1);
         for (int i = 0; i < CAPACITY; i++) begin
            if (SLOT_W'(i) == free_slot) begin
               valid_ff[i] <= 1'b1;
               rank_ff[i]  <= '0;
            end else if (valid_ff[i]) begin
               rank_ff[i] <= rank_ff[i] + SLOT_W'(1);
            end
         end
      end
   end

   assign ram_wr_en   = cmd.insert || (cmd.touch && cmd_ff == CMD_INSERT);
   assign ram_wr_addr = cmd.insert ? free_slot : slot_ff;

   lkhc_ram #(
      .WIDTH (HANDLE_W),
      .DEPTH (CAPACITY)
   ) u_handle_ram (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (ram_wr_addr),
      .wr_data (handle_ff),
      .rd_addr (slot_ff),
      .rd_data (ram_rd_data)
   );

   assign result_hit = hit_ff &&
      (cmd_ff == CMD_LOOKUP || (cmd_ff == CMD_INSERT && present_ff));

   always_ff @(posedge clock) begin
      if (cmd.rsp_load) begin
         rsp_hit_ff     <= result_hit;
         rsp_handle_ff  <= (result_hit && cmd_ff == CMD_LOOKUP) ? ram_rd_data : '0;
         rsp_evicted_ff <= (cmd_ff == CMD_INSERT && present_ff) ? evicted_ff : '0;
      end
   end

   assign rsp_hit           = rsp_hit_ff;
   assign rsp_handle_out    = rsp_handle_ff;
   assign rsp_evicted_count = rsp_evicted_ff;

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= COUNT_W'(CAPACITY))
      else $error("entry count above capacity");

   a_count_valid: assert property (@(posedge clock) disable iff (reset)
      $countones(valid_ff) == int'(count_ff))
      else $error("entry count disagrees with valid bits");

   a_clear_empty: assert property (@(posedge clock) disable iff (reset)
      cmd.clear |=> valid_ff == '0)
      else $error("clear left valid entries");

endmodule

[rtl/core/lru_keyed_handle_cache_unit.sv]
// Top level of the fully associative LRU keyed handle cache.
//
//   channel  direction  handshake             beat
//   req      in         req_valid/req_ready   cmd, key, handle_in, handle_present
//   rsp      out        rsp_valid/rsp_ready   hit, handle_out, evicted_count
//   csr      in         csr_valid/csr_ready   capacity_limit
//
// One request at a time: each runs through compare and resolve; a hit then updates
// recency, a clear empties the table, and an insert of a new key evicts the oldest
// entry while at the limit and then inserts; every request ends in the result state.
// The parallel tag compare, recency update pass and handle RAM read form these steps.
// Reset is synchronous; the table comes up empty with a limit of 64, no clearing pass.
// A stalled result is held in the output register; the next request runs up to its
// result state and waits there, with req_ready low, until the register frees.
module lru_keyed_handle_cache_unit import lkhc_pkg::*; (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_ready,
   input  logic [CMD_W-1:0]    req_cmd,
   input  logic [KEY_W-1:0]    req_key,
   input  logic [HANDLE_W-1:0] req_handle_in,
   input  logic                req_handle_present,
   output logic                rsp_valid,
   input  logic                rsp_ready,
   output logic                rsp_hit,
   output logic [HANDLE_W-1:0] rsp_handle_out,
   output logic [EVICT_W-1:0]  rsp_evicted_count,
   input  logic                csr_valid,
   output logic                csr_ready,
   input  logic [LIMIT_W-1:0]  csr_capacity_limit
);

   dp_cmd_type    dp_cmd;
   dp_status_type dp_status;

   assign csr_ready = 1'b1;

   lkhc_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .status    (dp_status),
      .cmd       (dp_cmd)
   );

   lkhc_dp u_dp (
      .clock              (clock),
      .reset              (reset),
      .cmd                (dp_cmd),
      .status             (dp_status),
      .req_cmd            (req_cmd),
      .req_key            (req_key),
      .req_handle_in      (req_handle_in),
      .req_handle_present (req_handle_present),
      .csr_valid          (csr_valid),
      .csr_capacity_limit (csr_capacity_limit),
      .rsp_hit            (rsp_hit),
      .rsp_handle_out     (rsp_handle_out),
      .rsp_evicted_count  (rsp_evicted_count)
   );

endmodule

[dv/lru_keyed_handle_cache_unit_tb.sv]
// Testbench for the LRU keyed handle cache: directed and random traffic checked against a table model.
`timescale 1ns / 1ps

module lru_keyed_handle_cache_unit_tb;
   import lkhc_pkg::*;

   localparam int CYCLE_LIMIT = 1500000;
   localparam int POOL_N      = 80;

   typedef struct {
      cmd_type               cmd;
      logic [KEY_W-1:0]      key;
      logic [HANDLE_W-1:0]   handle;
      logic                  present;
   } lookup_req_type;

   typedef struct {
      logic                  hit;
      logic [HANDLE_W-1:0]   handle;
      logic [EVICT_W-1:0]    evicted;
   } lookup_rsp_type;

   logic                clock;
   logic                reset;
   logic                req_valid;
   logic                req_ready;
   logic [CMD_W-1:0]    req_cmd;
   logic [KEY_W-1:0]    req_key;
   logic [HANDLE_W-1:0] req_handle_in;
   logic                req_handle_present;
   logic                rsp_valid;
   logic                rsp_ready;
   logic                rsp_hit;
   logic [HANDLE_W-1:0] rsp_handle_out;
   logic [EVICT_W-1:0]  rsp_evicted_count;
   logic                csr_valid;
   logic                csr_ready;
   logic [LIMIT_W-1:0]  csr_capacity_limit;

   lru_keyed_handle_cache_unit dut (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_ready(req_ready), .req_cmd(req_cmd),
      .req_key(req_key), .req_handle_in(req_handle_in),
      .req_handle_present(req_handle_present),
      .rsp_valid(rsp_valid), .rsp_ready(rsp_ready), .rsp_hit(rsp_hit),
      .rsp_handle_out(rsp_handle_out), .rsp_evicted_count(rsp_evicted_count),
      .csr_valid(csr_valid), .csr_ready(csr_ready),
      .csr_capacity_limit(csr_capacity_limit)
   );

   // table model
   logic [KEY_W-1:0]    tbl_key    [CAPACITY];
   logic [HANDLE_W-1:0] tbl_handle [CAPACITY];
   logic                tbl_valid  [CAPACITY];
   int unsigned         tbl_rank   [CAPACITY];
   int unsigned         tbl_count;
   int unsigned         cap_limit;

   lookup_req_type pending_reqs[$];
   lookup_rsp_type expected_rsps[$];
   logic [KEY_W-1:0] key_pool[POOL_N];
   int  errors;
   int  cycles;
   int  req_gap;
   int  rsp_gap;
   int  hold_cycles;
   bit  hold_request;

   always begin
      clock = 1'b0;
      #6;
      clock = 1'b1;
      #6;
   end

   function automatic int gap_len();
      int r;
      r = $urandom_range(0, 99);
      if (r < 50) return 0;
      if (r < 92) return $urandom_range(1, 3);
      return $urandom_range(10, 40);
   endfunction

   function automatic void touch_entry(int s);
      for (int i = 0; i < CAPACITY; i++)
         if (tbl_valid[i] && tbl_rank[i] < tbl_rank[s]) tbl_rank[i]++;
      tbl_rank[s] = 0;
   endfunction

   function automatic lookup_rsp_type predict_access(lookup_req_type r);
      lookup_rsp_type o;
      int s;
      int unsigned lim;
      o = '{1'b0, '0, '0};
      s = -1;
      for (int i = 0; i < CAPACITY; i++)
         if (s < 0 && tbl_valid[i] && tbl_key[i] == r.key) s = i;
      case (r.cmd)
         CMD_LOOKUP: if (s >= 0) begin
            o.hit = 1'b1;
            o.handle = tbl_handle[s];
            touch_entry(s);
         end
         CMD_INSERT: if (r.present) begin
            if (s >= 0) begin
               o.hit = 1'b1;
               tbl_handle[s] = r.handle;
               touch_entry(s);
            end else begin
               lim = (cap_limit > CAPACITY) ? CAPACITY : cap_limit;
               if (lim == 0) lim = 1;
               while (tbl_count >= lim && tbl_count > 0) begin
                  for (int i = 0; i < CAPACITY; i++)
                     if (tbl_valid[i] && tbl_rank[i] == tbl_count - 1) begin
                        tbl_valid[i] = 1'b0;
                        tbl_rank[i] = 0;
                        tbl_count--;
                        break;
                     end
                  o.evicted++;
               end
               for (int i = 0; i < CAPACITY; i++)
                  if (tbl_valid[i]) tbl_rank[i]++;
               for (int i = 0; i < CAPACITY; i++)
                  if (!tbl_valid[i]) begin
                     tbl_valid[i] = 1'b1;
                     tbl_key[i] = r.key;
                     tbl_handle[i] = r.handle;
                     tbl_rank[i] = 0;
                     tbl_count++;
                     break;
                  end
            end
         end
         CMD_CLEAR: begin
            for (int i = 0; i < CAPACITY; i++) begin
               tbl_valid[i] = 1'b0;
               tbl_rank[i] = 0;
            end
            tbl_count = 0;
         end
         default: ;
      endcase
      return o;
   endfunction

   // driver
   always @(posedge clock) begin
      lookup_req_type r;
      cycles <= cycles + 1;
      if (reset) begin
         req_valid <= 1'b0;
         req_gap <= 0;
      end else if (!req_valid || req_ready) begin
         if (req_valid) expected_rsps.insert(expected_rsps.size(),
            predict_access('{cmd_type'(req_cmd), req_key, req_handle_in,
            req_handle_present}));
         if (req_gap > 0 || pending_reqs.size() == 0) begin
            req_valid <= 1'b0;
            if (req_gap > 0) req_gap <= req_gap - 1;
         end else begin
            r = pending_reqs.pop_front();
            req_valid <= 1'b1;
            req_cmd <= r.cmd;
            req_key <= r.key;
            req_handle_in <= r.handle;
            req_handle_present <= r.present;
            req_gap <= gap_len();
         end
      end
   end

   // monitor and receiver
   always @(posedge clock) begin
      lookup_rsp_type e;
      if (reset) begin
         rsp_ready <= 1'b0;
         rsp_gap <= 0;
         hold_cycles <= 0;
      end else begin
         if (rsp_valid && rsp_ready) begin
            if (expected_rsps.size() == 0) begin
               errors++;
               if (errors <= 10) $display("unexpected beat: hit=%0b handle=%h evicted=%0d",
                  rsp_hit, rsp_handle_out, rsp_evicted_count);
            end else begin
               e = expected_rsps.pop_front();
               if (e.hit !== rsp_hit || e.handle !== rsp_handle_out ||
                   e.evicted !== rsp_evicted_count) begin
                  errors++;
                  if (errors <= 10)
                     $display("mismatch: exp hit=%0b handle=%h evicted=%0d, got %0b %h %0d",
                        e.hit, e.handle, e.evicted, rsp_hit, rsp_handle_out,
                        rsp_evicted_count);
               end
            end
         end
         if (hold_request && hold_cycles == 0) begin
            hold_request <= 1'b0;
            hold_cycles <= 400;
            rsp_ready <= 1'b0;
         end else if (hold_cycles > 0) begin
            hold_cycles <= hold_cycles - 1;
            rsp_ready <= (hold_cycles == 1);
         end else if (rsp_gap > 0) begin
            rsp_gap <= rsp_gap - 1;
            rsp_ready <= 1'b0;
         end else begin
            rsp_ready <= 1'b1;
            rsp_gap <= gap_len();
         end
      end
   end

   always @(posedge clock) begin
      if (cycles > CYCLE_LIMIT) begin
         $display("lru_keyed_handle_cache_unit_tb: FAIL");
         $finish;
      end
   end

   task automatic wait_idle();
      do @(posedge clock);
      while (pending_reqs.size() != 0 || req_valid || expected_rsps.size() != 0);
      repeat (8) @(posedge clock);
   endtask

   task automatic write_limit(int unsigned v);
      wait_idle();
      csr_valid <= 1'b1;
      csr_capacity_limit <= LIMIT_W'(v);
      do @(posedge clock);
      while (!csr_ready);
      cap_limit = v;
      csr_valid <= 1'b0;
   endtask

   function automatic void add_req(cmd_type c, logic [KEY_W-1:0] k,
                                   logic [HANDLE_W-1:0] h, logic p);
      pending_reqs.insert(pending_reqs.size(), '{c, k, h, p});
   endfunction

   function automatic void add_random(int n, int pool_n);
      int r;
      logic [KEY_W-1:0] k;
      cmd_type c;
      for (int i = 0; i < n; i++) begin
         r = $urandom_range(0, 99);
         k = ($urandom_range(0, 9) == 0) ? {$urandom, $urandom}
                                         : key_pool[$urandom_range(0, pool_n - 1)];
         c = (r < 47) ? CMD_LOOKUP : (r < 96) ? CMD_INSERT : (r < 98) ? CMD_NONE : CMD_CLEAR;
         add_req(c, k, $urandom, $urandom_range(0, 9) != 0);
      end
   endfunction

   initial begin
      int unsigned limits[10] = '{1, 64, 127, 0, 65, 5, 33, 2, 100, 16};
      reset = 1'b1;
      req_valid = 1'b0;
      req_cmd = '0;
      req_key = '0;
      req_handle_in = '0;
      req_handle_present = 1'b0;
      rsp_ready = 1'b0;
      csr_valid = 1'b0;
      csr_capacity_limit = '0;
      errors = 0;
      cycles = 0;
      hold_request = 1'b0;
      cap_limit = LIMIT_RESET;
      tbl_count = 0;
      for (int i = 0; i < CAPACITY; i++) begin
         tbl_valid[i] = 1'b0;
         tbl_rank[i] = 0;
         tbl_key[i] = '0;
         tbl_handle[i] = '0;
      end
      for (int i = 0; i < POOL_N; i++) key_pool[i] = {$urandom, $urandom};
      repeat (5) @(posedge clock);
      reset <= 1'b0;

      add_req(CMD_LOOKUP, '0, '0, 1'b0);
      add_req(CMD_INSERT, '0, '0, 1'b1);
      add_req(CMD_INSERT, '1, '1, 1'b1);
      add_req(CMD_LOOKUP, '0, '1, 1'b1);
      add_req(CMD_LOOKUP, '1, '0, 1'b0);
      add_req(CMD_INSERT, 64'h5a5a, 32'h1234, 1'b0);
      add_req(CMD_LOOKUP, 64'h5a5a, '0, 1'b0);
      add_req(CMD_NONE, '1, '1, 1'b1);
      add_req(CMD_INSERT, '0, 32'hcafe_f00d, 1'b1);
      add_req(CMD_LOOKUP, '0, '0, 1'b0);
      add_req(CMD_CLEAR, '1, '1, 1'b1);
      add_req(CMD_LOOKUP, '1, '0, 1'b0);
      for (int i = 0; i < 4; i++) add_req(CMD_INSERT, key_pool[i], $urandom, 1'b1);
      write_limit(0);
      for (int i = 0; i < 3; i++) add_req(CMD_INSERT, key_pool[i], $urandom, 1'b1);
      add_req(CMD_LOOKUP, key_pool[2], '0, 1'b0);
      write_limit(127);

      foreach (limits[p]) begin
         write_limit(limits[p]);
         if (p == 2) hold_request = 1'b1;
         add_random(185, (limits[p] < 8) ? 10 : POOL_N);
      end
      wait_idle();
      repeat (20) @(posedge clock);
      if (errors == 0)
         $display("lru_keyed_handle_cache_unit_tb: PASS");
      else
         $display("lru_keyed_handle_cache_unit_tb: FAIL");
      $finish;
   end

endmodule

[files.f]
rtl/core/lkhc_pkg.sv
rtl/core/lkhc_ram.sv
rtl/core/lkhc_ctrl.sv
rtl/core/lkhc_dp.sv
rtl/core/lru_keyed_handle_cache_unit.sv
dv/lru_keyed_handle_cache_unit_tb.sv
